/* rtl/bpc_pkg.sv */
// shared types and constants for the barometer pressure compensation unit
package bpc_pkg;

   // raw word layout
   localparam int WORD_W = 16;
   localparam int ADC_W  = 10;
   localparam int ADC_LSB = 6;

   // datapath widths
   localparam int COEFF_W  = 16;
   localparam int CROSS_W  = 14;
   localparam int SUM_W    = 37;
   localparam int PROD_W   = 54;
   localparam int MID_W    = 36;
   localparam int DIVIN_W  = 31;
   localparam int PRESS_W  = 21;
   localparam int TEMP_W   = 16;

   // pressure scaling
   localparam logic signed [PROD_W-1:0] PRESS_ROUND = 54'sd134086656;  // 1023 * 2^17
   localparam int                       PRESS_SHIFT = 18;
   localparam logic signed [MID_W-1:0]  CLIP_LO     = -36'sd818400000; // -800000 * 1023
   localparam logic signed [MID_W-1:0]  CLIP_HI     = 36'sd1326986496; // 1297152 * 1023
   localparam logic signed [MID_W-1:0]  PRESS_BIAS  = 36'sd818400000;
   localparam logic [21:0]              PRESS_RECIP = 22'd2099202;     // floor(2^31 / 1023)
   localparam logic [31:0]              PRESS_DIV   = 32'd1023;
   localparam logic [PRESS_W-1:0]       PRESS_MAX   = 21'h1FFFFF;

   // temperature scaling
   localparam logic [23:0] TEMP_NUM   = 24'd10475735;
   localparam logic [23:0] TEMP_RECIP = 24'd10034970; // floor(2^30 / 107)
   localparam logic [22:0] TEMP_DIV   = 23'd107;
   localparam logic [16:0] TEMP_BIAS  = 17'd18722;

   // pipeline depth from accept to result strobe
   localparam int LATENCY = 7;

   typedef enum logic [1:0] {
      CSR_OFFSET      = 2'd0,
      CSR_PRESS_SLOPE = 2'd1,
      CSR_TEMP_SLOPE  = 2'd2,
      CSR_CROSS       = 2'd3
   } csr_index_type;

endpackage

/* rtl/barometer_pressure_compensation_unit.sv */
// barometer pressure and temperature compensation, seven-stage pipeline
// throughput: one request per cycle, every stage advances each cycle and never stalls
// busy is high only while reset is high, so start is taken in any other cycle
// reset is synchronous: it clears the coefficients to zero and drops all in-flight requests
// the results cannot be held off, so the 7-stage depth is set by the pressure path multiplies
module barometer_pressure_compensation_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [bpc_pkg::WORD_W-1:0]        req_pressure_word,
   input  logic [bpc_pkg::WORD_W-1:0]        req_temperature_word,
   output logic                              rsp_strobe,
   output logic [bpc_pkg::PRESS_W-1:0]       rsp_pressure_sixteenth_pa,
   output logic                              rsp_pressure_clipped,
   output logic signed [bpc_pkg::TEMP_W-1:0] rsp_temperature_q8,
   input  logic                              csr_write_enable,
   input  logic [1:0]                        csr_index,
   input  logic [bpc_pkg::COEFF_W-1:0]       csr_write_data
);

   // ------------------------------------------------------------------
   // calibration registers
   // ------------------------------------------------------------------
   logic signed [bpc_pkg::COEFF_W-1:0] a0_ff;   // offset, Q12.3
   logic signed [bpc_pkg::COEFF_W-1:0] b1_ff;   // pressure slope, Q2.13
   logic signed [bpc_pkg::COEFF_W-1:0] b2_ff;   // temperature slope, Q1.14
   logic        [bpc_pkg::CROSS_W-1:0] c12_ff;  // cross term, unsigned Q0.22

   bpc_pkg::csr_index_type csr_sel;
   assign csr_sel = bpc_pkg::csr_index_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         a0_ff  <= '0;
         b1_ff  <= '0;
         b2_ff  <= '0;
         c12_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_sel)
            bpc_pkg::CSR_OFFSET:      a0_ff  <= csr_write_data;
            bpc_pkg::CSR_PRESS_SLOPE: b1_ff  <= csr_write_data;
            bpc_pkg::CSR_TEMP_SLOPE:  b2_ff  <= csr_write_data;
            bpc_pkg::CSR_CROSS:       c12_ff <= csr_write_data[bpc_pkg::CROSS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // handshake: every stage moves each cycle, only reset holds requests off
   // ------------------------------------------------------------------
   logic req_accept;
   assign busy       = reset;
   assign req_accept = start && !busy;

   logic [bpc_pkg::LATENCY-1:0] valid_ff;
   logic [bpc_pkg::LATENCY-1:0] valid_in;

   assign valid_in = {valid_ff[bpc_pkg::LATENCY-2:0], req_accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: adc codes, coefficient products, temperature numerator
   // ------------------------------------------------------------------
   logic        [bpc_pkg::ADC_W-1:0] p_code;
   logic        [bpc_pkg::ADC_W-1:0] t_code;
   logic signed [26:0]               bp_in, bp_ff;    // b1 * p
   logic signed [26:0]               bt_in, bt_ff;    // b2 * t
   logic        [23:0]               ct_in, ct_ff;    // c12 * t
   logic        [bpc_pkg::ADC_W-1:0] p1_in, p1_ff;
   logic        [22:0]               ty1_in, ty1_ff;  // half of the biased temperature numerator
   logic        [23:0]               tnum;

   assign p_code = req_pressure_word[bpc_pkg::WORD_W-1:bpc_pkg::ADC_LSB];
   assign t_code = req_temperature_word[bpc_pkg::WORD_W-1:bpc_pkg::ADC_LSB];

   always_comb begin
      bp_in = b1_ff * $signed({1'b0, p_code});
      bt_in = b2_ff * $signed({1'b0, t_code});
      ct_in = c12_ff * t_code;
      p1_in = p_code;
      // 10475735 - 10240*t, never negative
      tnum   = bpc_pkg::TEMP_NUM - (24'(t_code) << 13) - (24'(t_code) << 11);
      ty1_in = tnum[23:1];
   end

   // ------------------------------------------------------------------
   // stage 2: cross product, aligned partial sum, temperature quotient estimate
   // ------------------------------------------------------------------
   logic        [33:0]                ctp_in, ctp_ff;
   logic signed [bpc_pkg::SUM_W-1:0]  part_in, part_ff;
   logic        [15:0]                tq0_in, tq0_ff;
   logic        [22:0]                ty2_in, ty2_ff;
   logic        [46:0]                tprod;

   always_comb begin
      ctp_in  = ct_ff * p1_ff;
      part_in = (bpc_pkg::SUM_W'(a0_ff) <<< 19)
              + (bpc_pkg::SUM_W'(bp_ff) <<< 9)
              + (bpc_pkg::SUM_W'(bt_ff) <<< 8);
      tprod   = 47'(ty1_ff) * 47'(bpc_pkg::TEMP_RECIP);
      tq0_in  = tprod[45:30];
      ty2_in  = ty1_ff;
   end

   // ------------------------------------------------------------------
   // stage 3: full polynomial on the 2^-22 scale, temperature correction
   // ------------------------------------------------------------------
   logic signed [bpc_pkg::SUM_W-1:0]  s_in, s_ff;
   logic signed [bpc_pkg::TEMP_W-1:0] tq3_in, tq3_ff;
   logic        [22:0]                trem;
   logic        [16:0]                tquot;

   always_comb begin
      s_in  = part_ff + $signed({3'b000, ctp_ff});
      // estimate is low by at most one
      trem  = ty2_ff - 23'(tq0_ff * bpc_pkg::TEMP_DIV);
      tquot = 17'(tq0_ff) + ((trem >= bpc_pkg::TEMP_DIV) ? 17'd1 : 17'd0);
      tq3_in = bpc_pkg::TEMP_W'(tquot - bpc_pkg::TEMP_BIAS);
   end

   // ------------------------------------------------------------------
   // stage 4: scale by 65000 with shift-adds, add rounding half, drop 18 bits
   // ------------------------------------------------------------------
   logic signed [bpc_pkg::MID_W-1:0]  m_in, m_ff;
   logic signed [bpc_pkg::TEMP_W-1:0] tq4_ff;
   logic signed [bpc_pkg::PROD_W-1:0] sx;
   logic signed [bpc_pkg::PROD_W-1:0] scaled;

   always_comb begin
      sx     = bpc_pkg::PROD_W'(s_ff);
      // 65000 = 65536 - 512 - 16 - 8
      scaled = (sx <<< 16) - (sx <<< 9) - (sx <<< 4) - (sx <<< 3) + bpc_pkg::PRESS_ROUND;
      m_in   = scaled[bpc_pkg::PROD_W-1:bpc_pkg::PRESS_SHIFT];
   end

   // ------------------------------------------------------------------
   // stage 5: range check and bias into an unsigned dividend
   // ------------------------------------------------------------------
   logic                              lo5_in, lo5_ff;
   logic                              hi5_in, hi5_ff;
   logic        [bpc_pkg::DIVIN_W-1:0] x5_in, x5_ff;
   logic signed [bpc_pkg::MID_W-1:0]   biased;
   logic signed [bpc_pkg::TEMP_W-1:0]  tq5_ff;

   always_comb begin
      lo5_in = m_ff < bpc_pkg::CLIP_LO;
      hi5_in = m_ff >= bpc_pkg::CLIP_HI;
      biased = m_ff + bpc_pkg::PRESS_BIAS;
      // only meaningful when neither clip flag is set
      x5_in  = biased[bpc_pkg::DIVIN_W-1:0];
   end

   // ------------------------------------------------------------------
   // stage 6: divide by 1023 through the reciprocal
   // ------------------------------------------------------------------
   logic        [bpc_pkg::PRESS_W-1:0] q6_in, q6_ff;
   logic        [bpc_pkg::DIVIN_W-1:0] x6_ff;
   logic                               lo6_ff, hi6_ff;
   logic        [52:0]                 pprod;
   logic signed [bpc_pkg::TEMP_W-1:0]  tq6_ff;

   always_comb begin
      pprod = 53'(x5_ff) * 53'(bpc_pkg::PRESS_RECIP);
      q6_in = pprod[51:31];
   end

   // ------------------------------------------------------------------
   // stage 7: quotient correction and saturation into the result register
   // ------------------------------------------------------------------
   logic        [bpc_pkg::PRESS_W-1:0] press7_in, press7_ff;
   logic                               clip7_in, clip7_ff;
   logic                               lo7_ff, hi7_ff;
   logic signed [bpc_pkg::TEMP_W-1:0]  tq7_ff;
   logic        [31:0]                 prem;
   logic        [bpc_pkg::PRESS_W-1:0] pquot;

   always_comb begin
      // q*1023 = q*1024 - q
      prem  = 32'(x6_ff) - ((32'(q6_ff) << 10) - 32'(q6_ff));
      pquot = q6_ff + ((prem >= bpc_pkg::PRESS_DIV) ? 21'd1 : 21'd0);
      if (lo6_ff) begin
         press7_in = '0;
      end else if (hi6_ff) begin
         press7_in = bpc_pkg::PRESS_MAX;
      end else begin
         press7_in = pquot;
      end
      clip7_in = lo6_ff || hi6_ff;
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      bp_ff     <= bp_in;
      bt_ff     <= bt_in;
      ct_ff     <= ct_in;
      p1_ff     <= p1_in;
      ty1_ff    <= ty1_in;
      ctp_ff    <= ctp_in;
      part_ff   <= part_in;
      tq0_ff    <= tq0_in;
      ty2_ff    <= ty2_in;
      s_ff      <= s_in;
      tq3_ff    <= tq3_in;
      m_ff      <= m_in;
      tq4_ff    <= tq3_ff;
      lo5_ff    <= lo5_in;
      hi5_ff    <= hi5_in;
      x5_ff     <= x5_in;
      tq5_ff    <= tq4_ff;
      q6_ff     <= q6_in;
      x6_ff     <= x5_ff;
      lo6_ff    <= lo5_ff;
      hi6_ff    <= hi5_ff;
      tq6_ff    <= tq5_ff;
      press7_ff <= press7_in;
      clip7_ff  <= clip7_in;
      lo7_ff    <= lo6_ff;
      hi7_ff    <= hi6_ff;
      tq7_ff    <= tq6_ff;
   end

   assign rsp_strobe                = valid_ff[bpc_pkg::LATENCY-1];
   assign rsp_pressure_sixteenth_pa = press7_ff;
   assign rsp_pressure_clipped      = clip7_ff;
   assign rsp_temperature_q8        = tq7_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(req_accept, bpc_pkg::LATENCY))
      else $error("result strobe does not follow an accepted request");

   a_clip_value : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_pressure_clipped) |->
      (rsp_pressure_sixteenth_pa == '0 || rsp_pressure_sixteenth_pa == bpc_pkg::PRESS_MAX))
      else $error("clipped pressure is not at a range limit");

   a_clip_excl : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(lo7_ff && hi7_ff))
      else $error("pressure clipped both low and high");

   // code 0 gives the top value, code 1023 gives -18721, one above the bottom bound
   a_temp_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_temperature_q8 >= -16'sd18722 && rsp_temperature_q8 <= 16'sd30230))
      else $error("temperature result out of its range");

endmodule
